[hw/rtl/crcfr_pkg.sv]
// shared types, codes and constants for the crc-32 checked frame receiver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package crcfr_pkg;

  localparam int FRAME_LEN_W = 18;
  localparam int TIMEOUT_W   = 16;
  localparam int ADDR_W      = 17;
  localparam int CRC_W       = 32;
  localparam int BYTE_W      = 8;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 18;

  localparam int DEFAULT_MAX_FRAME_BYTES = 131072;

  localparam logic [CRC_W-1:0]       CRC_POLY        = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0]       CRC_PRESET      = 32'hFFFF_FFFF;
  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = 18'd96000;
  localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET   = 16'd3000;
  localparam logic [TIMEOUT_W-1:0]   TIMEOUT_SAT     = 16'hFFFF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_BEGIN = 2'd0,
    FUNC_DATA  = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_ABORT = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_IDLE     = 3'd0,
    ST_ARMED    = 3'd1,
    ST_STORED   = 3'd2,
    ST_VERIFIED = 3'd3,
    ST_MISMATCH = 3'd4,
    ST_TIMEOUT  = 3'd5,
    ST_ABORTED  = 3'd6,
    ST_IGNORED  = 3'd7
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_LENGTH = 1'd0,
    REG_IDLE_TIMEOUT = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [FRAME_LEN_W-1:0] frame_length;
    logic [TIMEOUT_W-1:0]   idle_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    status_t                status;
    logic                   store_write;
    logic [ADDR_W-1:0]      store_address;
    logic [BYTE_W-1:0]      store_data;
    logic [FRAME_LEN_W-1:0] bytes_received;
    logic [CRC_W-1:0]       final_crc;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/crc32_checked_frame_receiver.sv]
// top level: request register, frame core, result register, config port
// depends on crcfr_pkg, crcfr_cfg, crcfr_core, crcfr_crc8
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    func, data_byte, expected_crc
//  out      source     out_valid / out_stall  status, store_write, store_address,
//                                             store_data, bytes_received, final_crc
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one request per cycle while not stalled; request register, then result register
// the byte-wide crc update and the frame length compare sit between the two registers
// synchronous reset restores frame_length 96000 and idle timeout 3000, frame disarmed
// in_stall is high only while the request register holds a request and the result
// register is full and stalled
`timescale 1ns / 1ps
`default_nettype none

module crc32_checked_frame_receiver
  import crcfr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
  input  wire logic                   clk,
  input  wire logic                   rst,

  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [FUNC_W-1:0]      func,
  input  wire logic [BYTE_W-1:0]      data_byte,
  input  wire logic [CRC_W-1:0]       expected_crc,

  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [STATUS_W-1:0]         status,
  output logic                        store_write,
  output logic [ADDR_W-1:0]           store_address,
  output logic [BYTE_W-1:0]           store_data,
  output logic [FRAME_LEN_W-1:0]      bytes_received,
  output logic [CRC_W-1:0]            final_crc,

  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t              cfg;
  res_t              res;
  res_t              out_res;

  logic              req_valid;
  logic [FUNC_W-1:0] req_func;
  logic [BYTE_W-1:0] req_byte;
  logic [CRC_W-1:0]  req_crc;

  logic              out_load;
  logic              advance;

  assign out_load = !out_valid || !out_stall;
  assign advance  = req_valid && out_load;
  assign in_stall = req_valid && !out_load;

  crcfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  crcfr_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .func         (req_func),
    .data_byte    (req_byte),
    .expected_crc (req_crc),
    .cfg          (cfg),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_func <= func;
      req_byte <= data_byte;
      req_crc  <= expected_crc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign status         = out_res.status;
  assign store_write    = out_res.store_write;
  assign store_address  = out_res.store_address;
  assign store_data     = out_res.store_data;
  assign bytes_received = out_res.bytes_received;
  assign final_crc      = out_res.final_crc;

  // a verdict always comes with the byte that closed the frame
  a_verdict_stores: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.status == ST_VERIFIED || out_res.status == ST_MISMATCH)
      |-> out_res.store_write)
    else $error("verdict without stored byte");

  // store writes only for stored or closing bytes
  a_write_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.store_write
      |-> (out_res.status == ST_STORED || out_res.status == ST_VERIFIED ||
           out_res.status == ST_MISMATCH))
    else $error("store write with wrong status");

  // final crc only reported with a verdict
  a_crc_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.status != ST_VERIFIED && out_res.status != ST_MISMATCH
      |-> out_res.final_crc == '0)
    else $error("final crc outside verdict");

  // stall only when a request is held and the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (req_valid && out_valid && out_stall))
    else $error("spurious input stall");

  // a blocked result is not overwritten
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("stalled result changed");

endmodule

`default_nettype wire

[hw/rtl/crcfr_crc8.sv]
// reflected crc-32 update over one byte, eight bit steps unrolled
// depends on crcfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module crcfr_crc8
  import crcfr_pkg::*;
(
  input  wire logic [CRC_W-1:0]  crc_in,
  input  wire logic [BYTE_W-1:0] data_in,
  output logic      [CRC_W-1:0]  crc_out
);

  logic [CRC_W-1:0] c;

  always_comb begin
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
    for (int i = 0; i < BYTE_W; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

[hw/rtl/crcfr_cfg.sv]
// configuration registers: frame length and idle timeout
// depends on crcfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module crcfr_cfg
  import crcfr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_length       <= FRAME_LEN_RESET;
      cfg.idle_timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_LENGTH: cfg.frame_length <= cfg_data[FRAME_LEN_W-1:0];
        REG_IDLE_TIMEOUT: cfg.idle_timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/crcfr_core.sv]
// frame state and per-request result logic
// depends on crcfr_pkg and crcfr_crc8
`timescale 1ns / 1ps
`default_nettype none

module crcfr_core
  import crcfr_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic [FUNC_W-1:0] func,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic [CRC_W-1:0]  expected_crc,
  input  wire cfg_t              cfg,
  output res_t                   res
);

  localparam int LEN_MAX_REP = (1 << FRAME_LEN_W) - 1;
  localparam logic [FRAME_LEN_W-1:0] LEN_CAP =
    FRAME_LEN_W'((MAX_FRAME_BYTES > LEN_MAX_REP) ? LEN_MAX_REP : MAX_FRAME_BYTES);

  logic                   armed;
  logic                   armed_next;
  logic [FRAME_LEN_W-1:0] byte_count;
  logic [FRAME_LEN_W-1:0] byte_count_next;
  logic [CRC_W-1:0]       running_crc;
  logic [CRC_W-1:0]       running_crc_next;
  logic [CRC_W-1:0]       target_crc;
  logic [CRC_W-1:0]       target_crc_next;
  logic [TIMEOUT_W-1:0]   idle_count;
  logic [TIMEOUT_W-1:0]   idle_count_next;

  logic [CRC_W-1:0]       crc_upd;
  logic [CRC_W-1:0]       crc_fin;
  logic [FRAME_LEN_W-1:0] len;
  logic [TIMEOUT_W-1:0]   tmo;
  logic [FRAME_LEN_W-1:0] count_inc;
  logic [TIMEOUT_W-1:0]   idle_inc;

  crcfr_crc8 u_crc8 (
    .crc_in  (running_crc),
    .data_in (data_byte),
    .crc_out (crc_upd)
  );

  always_comb begin
    len = cfg.frame_length;
    if (len == '0) begin
      len = FRAME_LEN_W'(1);
    end else if (len > LEN_CAP) begin
      len = LEN_CAP;
    end
    tmo = (cfg.idle_timeout_ticks == '0) ? TIMEOUT_W'(1) : cfg.idle_timeout_ticks;
    count_inc = byte_count + FRAME_LEN_W'(1);
    idle_inc  = (idle_count == TIMEOUT_SAT) ? idle_count : idle_count + TIMEOUT_W'(1);
    crc_fin   = ~crc_upd;

    armed_next       = armed;
    byte_count_next  = byte_count;
    running_crc_next = running_crc;
    target_crc_next  = target_crc;
    idle_count_next  = idle_count;

    res                = '0;
    res.status         = ST_IDLE;

    case (func_t'(func))
      FUNC_BEGIN: begin
        armed_next       = 1'b1;
        byte_count_next  = '0;
        running_crc_next = CRC_PRESET;
        target_crc_next  = expected_crc;
        idle_count_next  = '0;
        res.status       = ST_ARMED;
      end
      FUNC_DATA: begin
        if (!armed) begin
          res.status = ST_IGNORED;
        end else begin
          res.store_write    = 1'b1;
          res.store_address  = byte_count[ADDR_W-1:0];
          res.store_data     = data_byte;
          res.bytes_received = count_inc;
          if (count_inc >= len) begin
            res.final_crc    = crc_fin;
            res.status       = (crc_fin == target_crc) ? ST_VERIFIED : ST_MISMATCH;
            armed_next       = 1'b0;
            byte_count_next  = '0;
            running_crc_next = CRC_PRESET;
            target_crc_next  = '0;
            idle_count_next  = '0;
          end else begin
            res.status       = ST_STORED;
            byte_count_next  = count_inc;
            running_crc_next = crc_upd;
            idle_count_next  = '0;
          end
        end
      end
      FUNC_TICK: begin
        if (armed) begin
          res.bytes_received = byte_count;
          if (idle_inc >= tmo) begin
            res.status       = ST_TIMEOUT;
            armed_next       = 1'b0;
            byte_count_next  = '0;
            running_crc_next = CRC_PRESET;
            target_crc_next  = '0;
            idle_count_next  = '0;
          end else begin
            res.status      = ST_ARMED;
            idle_count_next = idle_inc;
          end
        end
      end
      FUNC_ABORT: begin
        res.bytes_received = byte_count;
        res.status         = ST_ABORTED;
        armed_next         = 1'b0;
        byte_count_next    = '0;
        running_crc_next   = CRC_PRESET;
        target_crc_next    = '0;
        idle_count_next    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed       <= 1'b0;
      byte_count  <= '0;
      running_crc <= CRC_PRESET;
      target_crc  <= '0;
      idle_count  <= '0;
    end else if (advance) begin
      armed       <= armed_next;
      byte_count  <= byte_count_next;
      running_crc <= running_crc_next;
      target_crc  <= target_crc_next;
      idle_count  <= idle_count_next;
    end
  end

endmodule

`default_nettype wire

[verif/crc32_checked_frame_receiver_tb.sv]
// testbench for crc32_checked_frame_receiver: directed and random frames, config sweeps,
// random idling on both channels, results checked against a crc-32 frame predictor
// depends on crcfr_pkg and the crc32_checked_frame_receiver rtl
`timescale 1ns / 1ps

import crcfr_pkg::*;

function automatic logic [CRC_W-1:0] crc_fold(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
  logic [CRC_W-1:0] r;
  r = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
  for (int i = 0; i < 8; i++) begin
    r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
  end
  return r;
endfunction

class frame_result_board;
  logic [FRAME_LEN_W-1:0] len_reg;
  logic [TIMEOUT_W-1:0]   tmo_reg;
  bit                     armed;
  logic [FRAME_LEN_W-1:0] byte_total;
  logic [CRC_W-1:0]       crc_run;
  logic [CRC_W-1:0]       crc_target;
  logic [TIMEOUT_W-1:0]   idle_ticks;
  res_t                   awaited[$];
  int                     errors;

  function new();
    len_reg = FRAME_LEN_RESET;
    tmo_reg = TIMEOUT_RESET;
    errors  = 0;
    drop_frame();
  endfunction

  function void drop_frame();
    armed      = 1'b0;
    byte_total = '0;
    crc_run    = CRC_PRESET;
    crc_target = '0;
    idle_ticks = '0;
  endfunction

  function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    if (idx == REG_FRAME_LENGTH) begin
      len_reg = val[FRAME_LEN_W-1:0];
    end else begin
      tmo_reg = val[TIMEOUT_W-1:0];
    end
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  // notes an accepted request and queues the result it must produce
  function void predict_request(func_t f, logic [BYTE_W-1:0] b, logic [CRC_W-1:0] c);
    int   len;
    int   tmo;
    res_t r;
    len = (len_reg == 0) ? 1 : int'(len_reg);
    if (len > DEFAULT_MAX_FRAME_BYTES) len = DEFAULT_MAX_FRAME_BYTES;
    tmo = (tmo_reg == 0) ? 1 : int'(tmo_reg);
    r = '0;
    r.status = ST_IDLE;
    case (f)
      FUNC_BEGIN: begin
        drop_frame();
        crc_target = c;
        armed      = 1'b1;
        r.status   = ST_ARMED;
      end
      FUNC_DATA: begin
        if (!armed) begin
          r.status = ST_IGNORED;
        end else begin
          r.store_write    = 1'b1;
          r.store_address  = byte_total[ADDR_W-1:0];
          r.store_data     = b;
          crc_run          = crc_fold(crc_run, b);
          byte_total       = byte_total + 1'b1;
          idle_ticks       = '0;
          r.bytes_received = byte_total;
          if (int'(byte_total) >= len) begin
            r.final_crc = ~crc_run;
            r.status    = (r.final_crc == crc_target) ? ST_VERIFIED : ST_MISMATCH;
            drop_frame();
          end else begin
            r.status = ST_STORED;
          end
        end
      end
      FUNC_TICK: begin
        if (armed) begin
          if (idle_ticks != TIMEOUT_SAT) idle_ticks = idle_ticks + 1'b1;
          r.bytes_received = byte_total;
          if (int'(idle_ticks) >= tmo) begin
            r.status = ST_TIMEOUT;
            drop_frame();
          end else begin
            r.status = ST_ARMED;
          end
        end
      end
      default: begin
        r.bytes_received = byte_total;
        r.status         = ST_ABORTED;
        drop_frame();
      end
    endcase
    awaited.push_back(r);
  endfunction

  function void flag(string what, longint unsigned want_v, longint unsigned got_v);
    errors++;
    if (errors <= 10) $display("mismatch on %s: expected %0h, got %0h", what, want_v, got_v);
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (awaited.size() == 0) begin
      flag("result with no request, status", 0, got.status);
      return;
    end
    want = awaited.pop_front();
    if (got.status != want.status) flag("status", want.status, got.status);
    if (got.store_write != want.store_write) flag("store_write", want.store_write, got.store_write);
    if (got.store_address != want.store_address) begin
      flag("store_address", want.store_address, got.store_address);
    end
    if (got.store_data != want.store_data) flag("store_data", want.store_data, got.store_data);
    if (got.bytes_received != want.bytes_received) begin
      flag("bytes_received", want.bytes_received, got.bytes_received);
    end
    if (got.final_crc != want.final_crc) flag("final_crc", want.final_crc, got.final_crc);
  endfunction
endclass

module tb;
  import crcfr_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 950;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [FUNC_W-1:0]      func;
  logic [BYTE_W-1:0]      data_byte;
  logic [CRC_W-1:0]       expected_crc;
  logic                   out_valid;
  logic                   out_stall;
  logic [STATUS_W-1:0]    status;
  logic                   store_write;
  logic [ADDR_W-1:0]      store_address;
  logic [BYTE_W-1:0]      store_data;
  logic [FRAME_LEN_W-1:0] bytes_received;
  logic [CRC_W-1:0]       final_crc;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  frame_result_board results;
  res_t              seen;
  bit                steady = 1'b0;
  bit                hold_req = 1'b0;
  int                len_eff;
  int                tmo_eff;
  int                burst_max = 1;
  int                random_items;
  longint            cycles = 0;

  crc32_checked_frame_receiver u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .data_byte      (data_byte),
    .expected_crc   (expected_crc),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .store_write    (store_write),
    .store_address  (store_address),
    .store_data     (store_data),
    .bytes_received (bytes_received),
    .final_crc      (final_crc),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen.status         = status_t'(status);
      seen.store_write    = store_write;
      seen.store_address  = store_address;
      seen.store_data     = store_data;
      seen.bytes_received = bytes_received;
      seen.final_crc      = final_crc;
      results.check_result(seen);
    end
  end

  // result side: random stall per result, one long hold-off on request
  initial begin
    int k;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        k = 80;
      end else begin
        k = steady ? 0 : $urandom_range(0, 3);
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [CRC_W-1:0] frame_crc(logic [BYTE_W-1:0] body[$]);
    logic [CRC_W-1:0] c;
    c = CRC_PRESET;
    foreach (body[j]) c = crc_fold(c, body[j]);
    return ~c;
  endfunction

  function automatic int short_len();
    return $urandom_range(0, (len_eff > 20) ? 20 : len_eff - 1);
  endfunction

  task automatic send(func_t f, logic [BYTE_W-1:0] b, logic [CRC_W-1:0] c);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    data_byte    <= b;
    expected_crc <= c;
    do @(posedge clk); while (in_stall);
    results.predict_request(f, b, c);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    results.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (results.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_tick();
    send(FUNC_TICK, BYTE_W'($urandom), $urandom);
    random_items++;
  endtask

  // begin request with the frame crc (optionally one bit flipped), then bytes and ticks
  task automatic run_frame(int n, bit corrupt, int tick_pct);
    logic [BYTE_W-1:0] body[$];
    logic [CRC_W-1:0]  want;
    body = {};
    repeat (n) body.push_back(BYTE_W'($urandom));
    want = frame_crc(body);
    if (corrupt) want = want ^ (32'd1 << $urandom_range(0, 31));
    send(FUNC_BEGIN, BYTE_W'($urandom), want);
    random_items++;
    foreach (body[j]) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        repeat ($urandom_range(1, burst_max)) send_tick();
      end
      send(FUNC_DATA, body[j], $urandom);
      random_items++;
    end
  endtask

  initial begin
    logic [BYTE_W-1:0]     bytes[$];
    logic [CFG_DATA_W-1:0] len_val;
    logic [CFG_DATA_W-1:0] tmo_val;
    int                    sel;
    int                    kind;
    int                    phase_no;
    func_t                 f;

    results = new();
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    func         <= FUNC_BEGIN;
    data_byte    <= '0;
    expected_crc <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_FRAME_LENGTH;
    cfg_data     <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle behavior under reset settings
    send(FUNC_DATA, 8'hFF, 32'hFFFF_FFFF);
    send(FUNC_TICK, 8'h00, 32'h0000_0000);
    send(FUNC_ABORT, 8'hA5, 32'h5A5A_5A5A);
    settle();

    // zero length and zero timeout act as one
    cfg_write(REG_FRAME_LENGTH, '0);
    cfg_write(REG_IDLE_TIMEOUT, '0);
    bytes = '{8'h00};
    send(FUNC_BEGIN, 8'h00, frame_crc(bytes));
    send(FUNC_DATA, 8'h00, 32'h0);
    send(FUNC_BEGIN, 8'h00, 32'h0);
    send(FUNC_TICK, 8'h00, 32'h0);
    send(FUNC_BEGIN, 8'hFF, 32'hFFFF_FFFF);
    send(FUNC_ABORT, 8'h00, 32'h0);
    settle();

    // restart while armed, then length lowered mid-frame
    cfg_write(REG_FRAME_LENGTH, CFG_DATA_W'(4));
    cfg_write(REG_IDLE_TIMEOUT, CFG_DATA_W'(2));
    send(FUNC_BEGIN, 8'h00, 32'hDEAD_BEEF);
    send(FUNC_DATA, 8'hFF, 32'h0);
    send(FUNC_TICK, 8'h00, 32'h0);
    send(FUNC_DATA, 8'h00, 32'h0);
    send(FUNC_DATA, 8'hAA, 32'h0);
    bytes = '{8'h55, 8'h12};
    send(FUNC_BEGIN, 8'h00, frame_crc(bytes));
    send(FUNC_DATA, 8'h55, 32'h0);
    settle();
    cfg_write(REG_FRAME_LENGTH, CFG_DATA_W'(1));
    send(FUNC_DATA, 8'h12, 32'h0);
    settle();

    // length above the maximum, timeout with all data bits set
    cfg_write(REG_FRAME_LENGTH, '1);
    cfg_write(REG_IDLE_TIMEOUT, '1);
    send(FUNC_BEGIN, 8'h00, 32'h8000_0001);
    send(FUNC_DATA, 8'h80, 32'h0);
    send(FUNC_ABORT, 8'h00, 32'h0);
    settle();

    random_items = 0;
    phase_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) len_val = '0;
      else if (sel == 1) len_val = CFG_DATA_W'($urandom);
      else if (sel == 2) len_val = CFG_DATA_W'($urandom_range(13, 40));
      else len_val = CFG_DATA_W'($urandom_range(1, 12));
      tmo_val = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom)
                                            : CFG_DATA_W'($urandom_range(0, 6));
      cfg_write(REG_FRAME_LENGTH, len_val);
      cfg_write(REG_IDLE_TIMEOUT, tmo_val);
      len_eff = (len_val == 0) ? 1 : int'(len_val);
      if (len_eff > DEFAULT_MAX_FRAME_BYTES) len_eff = DEFAULT_MAX_FRAME_BYTES;
      tmo_eff = (tmo_val[TIMEOUT_W-1:0] == 0) ? 1 : int'(tmo_val[TIMEOUT_W-1:0]);
      burst_max = (tmo_eff < 8) ? tmo_eff : 8;
      steady = (phase_no != 2) && ($urandom_range(0, 4) == 0);
      if (phase_no == 2) hold_req = 1'b1;

      repeat ((phase_no == 2) ? 8 : $urandom_range(2, 5)) begin
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
          run_frame((len_eff <= 64) ? len_eff : $urandom_range(1, 20),
                    $urandom_range(0, 2) == 0, 15);
        end else if (kind == 6) begin
          run_frame(short_len(), 1'b0, 10);
          send(FUNC_ABORT, BYTE_W'($urandom), $urandom);
          random_items++;
        end else if (kind == 7 && tmo_eff <= 16) begin
          run_frame(short_len(), 1'b0, 0);
          repeat (tmo_eff) send_tick();
        end else if (kind == 8) begin
          repeat ($urandom_range(1, 6)) begin
            f = func_t'($urandom_range(0, 3));
            send(f, BYTE_W'($urandom), $urandom);
            if (f != FUNC_DATA) random_items++;
          end
        end else begin
          run_frame(short_len(), $urandom_range(0, 1), 10);
        end
      end
      settle();
      phase_no++;
    end

    steady = 1'b0;
    settle();
    if (results.errors == 0 && results.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
